// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define DQ_ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that, when seen, implies a consequence in the same cycle.
`define DQ_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// A condition that, when seen, implies a consequence in the next cycle.
`define DQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/dq_pkg.sv
// Types and constants of the double-ended queue.
package dq_pkg;

   localparam int KIND_W      = 3;
   localparam int VALUE_W     = 32;
   localparam int INDEX_W     = 4;
   localparam int STATUS_W    = 2;
   localparam int LEN_W       = 5;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 40;

   typedef enum logic [KIND_W-1:0] {
      RQ_PUSH_BACK  = 3'd0,
      RQ_PUSH_FRONT = 3'd1,
      RQ_POP_BACK   = 3'd2,
      RQ_POP_FRONT  = 3'd3,
      RQ_READ       = 3'd4
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_op_type;

   typedef struct packed {
      status_type         status;
      logic               has_data;
      logic [LEN_W-1:0]   length;
   } result_type;

endpackage

// File: hw/rtl/double_ended_queue.sv
// Top level of the bounded double-ended queue.
//
//   Channel   Role     Payload
//   req_*     input    tuser: request kind; tdata: value, index
//   rsp_*     output   tuser: status; tdata: data, length
//
// A request is decoded and applied to the head pointer and count in the cycle it
// is taken; the ring store is written or read at the same edge.
// Its result appears in the next cycle, with the read word from the store's
// registered port. One request per cycle is sustained while results are taken.
// A stalled result holds, and a new request is taken in the cycle its result
// leaves. Reset clears the pointer and count; the store needs no clearing.
module double_ended_queue #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [31:0] value, [35:32] index, [39:36] zero
   input  logic [dq_pkg::REQ_TDATA_W-1:0] req_tdata,
   // [2:0] req_type
   input  logic [dq_pkg::KIND_W-1:0]      req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [31:0] data, [36:32] length, [39:37] zero
   output logic [dq_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // [1:0] status
   output logic [dq_pkg::STATUS_W-1:0]    rsp_tuser
);

   localparam int SW = (DATA_WIDTH < dq_pkg::VALUE_W) ? DATA_WIDTH : dq_pkg::VALUE_W;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       accept;
   dq_pkg::mem_op_type         op;
   logic [$clog2(DEPTH)-1:0]   addr;
   logic [SW-1:0]              wdata, rdata;
   dq_pkg::result_type         result;
   logic [dq_pkg::VALUE_W-1:0] data_out;

   assign req_tready   = !reset && (!rsp_valid_ff || rsp_tready);
   assign accept       = req_tvalid && req_tready;
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   dq_ctrl #(
      .DEPTH (DEPTH),
      .SW    (SW)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_kind (req_tuser),
      .value    (req_tdata[dq_pkg::VALUE_W-1:0]),
      .index    (req_tdata[dq_pkg::VALUE_W +: dq_pkg::INDEX_W]),
      .op       (op),
      .addr     (addr),
      .wdata    (wdata),
      .result   (result)
   );

   dq_store #(
      .DEPTH (DEPTH),
      .WIDTH (SW)
   ) u_store (
      .clock (clock),
      .op    (op),
      .addr  (addr),
      .wdata (wdata),
      .rdata (rdata)
   );

   // Pushes, errors and unknown requests give a zero data word.
   always_comb begin
      data_out = '0;
      if (result.has_data) begin
         data_out[SW-1:0] = rdata;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = result.status;
   assign rsp_tdata  = {(dq_pkg::RSP_TDATA_W - dq_pkg::VALUE_W - dq_pkg::LEN_W)'(0),
                        result.length, data_out};

endmodule

// File: hw/rtl/dq_store.sv
// Ring store of the queue: one synchronous port, read data registered.
module dq_store #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  dq_pkg::mem_op_type       op,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // The read register only loads on a read, so it holds while the result stalls.
   always_ff @(posedge clock) begin
      if (op.wr_en) begin
         mem_ff[addr] <= wdata;
      end
      if (op.rd_en) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: hw/rtl/dq_ctrl.sv
// Request decode, head pointer and entry count of the queue.
module dq_ctrl #(
   parameter int DEPTH = 16,
   parameter int SW    = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  logic [dq_pkg::KIND_W-1:0]  req_kind,
   input  logic [dq_pkg::VALUE_W-1:0] value,
   input  logic [dq_pkg::INDEX_W-1:0] index,
   output dq_pkg::mem_op_type         op,
   output logic [$clog2(DEPTH)-1:0]   addr,
   output logic [SW-1:0]              wdata,
   output dq_pkg::result_type         result
);

   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int SUM_W = CW + 1;
   localparam int IW    = (CW > dq_pkg::INDEX_W) ? CW : dq_pkg::INDEX_W;
   localparam int LW    = (CW < dq_pkg::LEN_W) ? CW : dq_pkg::LEN_W;

   logic [AW-1:0]      head_ff, head_in;
   logic [CW-1:0]      count_ff, count_in;
   dq_pkg::result_type result_ff, result_in;
   dq_pkg::mem_op_type op_raw;
   logic               full, empty;

   // Offsets never exceed DEPTH, so one conditional subtract wraps the sum.
   function automatic logic [AW-1:0] ring_at(input logic [AW-1:0] h,
                                             input logic [CW-1:0] off);
      logic [SUM_W-1:0] s;
      begin
         s = SUM_W'(h) + SUM_W'(off);
         if (s >= SUM_W'(DEPTH)) begin
            s = s - SUM_W'(DEPTH);
         end
         return s[AW-1:0];
      end
   endfunction

   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);
   assign wdata = value[SW-1:0];

   always_comb begin
      head_in          = head_ff;
      count_in         = count_ff;
      op_raw           = '0;
      addr             = head_ff;
      result_in.status = dq_pkg::ST_OK;
      result_in.has_data = 1'b0;
      case (req_kind)
         dq_pkg::RQ_PUSH_BACK: begin
            if (full) begin
               result_in.status = dq_pkg::ST_FULL;
            end else begin
               op_raw.wr_en = 1'b1;
               addr         = ring_at(head_ff, count_ff);
               count_in     = count_ff + 1'b1;
            end
         end
         dq_pkg::RQ_PUSH_FRONT: begin
            if (full) begin
               result_in.status = dq_pkg::ST_FULL;
            end else begin
               op_raw.wr_en = 1'b1;
               addr         = ring_at(head_ff, CW'(DEPTH - 1));
               head_in      = addr;
               count_in     = count_ff + 1'b1;
            end
         end
         dq_pkg::RQ_POP_BACK: begin
            if (empty) begin
               result_in.status = dq_pkg::ST_EMPTY;
            end else begin
               op_raw.rd_en       = 1'b1;
               result_in.has_data = 1'b1;
               addr               = ring_at(head_ff, count_ff - 1'b1);
               count_in           = count_ff - 1'b1;
            end
         end
         dq_pkg::RQ_POP_FRONT: begin
            if (empty) begin
               result_in.status = dq_pkg::ST_EMPTY;
            end else begin
               op_raw.rd_en       = 1'b1;
               result_in.has_data = 1'b1;
               addr               = head_ff;
               head_in            = ring_at(head_ff, CW'(1));
               count_in           = count_ff - 1'b1;
            end
         end
         dq_pkg::RQ_READ: begin
            if (IW'(index) >= IW'(count_ff)) begin
               result_in.status = dq_pkg::ST_EMPTY;
            end else begin
               op_raw.rd_en       = 1'b1;
               result_in.has_data = 1'b1;
               addr               = ring_at(head_ff, CW'(index));
            end
         end
         default: begin
         end
      endcase
      result_in.length         = '0;
      result_in.length[LW-1:0] = count_in[LW-1:0];
   end

   assign op.wr_en = op_raw.wr_en & accept;
   assign op.rd_en = op_raw.rd_en & accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else if (accept) begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

// File: hw/rtl/dq_checker.sv
// Port-level checks of the double-ended queue, bound to its top level.
`include "assert_macros.svh"

module dq_checker #(
   parameter int DEPTH = 16
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [dq_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic [dq_pkg::STATUS_W-1:0]    rsp_tuser
);

   logic                        rsp_err;
   logic                        rsp_full;
   logic                        rsp_code_ok;
   logic [dq_pkg::LEN_W-1:0]    rsp_len;
   logic [dq_pkg::VALUE_W-1:0]  rsp_data;

   assign rsp_err     = rsp_tvalid && (rsp_tuser != dq_pkg::ST_OK);
   assign rsp_full    = rsp_tvalid && (rsp_tuser == dq_pkg::ST_FULL);
   assign rsp_code_ok = (rsp_tuser == dq_pkg::ST_OK) || (rsp_tuser == dq_pkg::ST_EMPTY) ||
                        (rsp_tuser == dq_pkg::ST_FULL);
   assign rsp_len     = rsp_tdata[dq_pkg::VALUE_W +: dq_pkg::LEN_W];
   assign rsp_data    = rsp_tdata[dq_pkg::VALUE_W-1:0];

   // A waiting result must not change under a stall.
   `DQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
                   rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser),
                   "result changed while stalled")

   // With no result pending the block must take a request.
   `DQ_ASSERT_IMPLY(a_ready_when_free, clock, reset, !rsp_tvalid, req_tready,
                    "request refused with output free")

   // An error never carries a data word.
   `DQ_ASSERT_IMPLY(a_err_no_data, clock, reset, rsp_err, rsp_data == '0,
                    "error result with nonzero data")

   // A push is refused only when the queue holds DEPTH entries.
   `DQ_ASSERT_IMPLY(a_full_len, clock, reset, rsp_full, rsp_len == dq_pkg::LEN_W'(DEPTH),
                    "full status with short length")

   // Every status code on the port is a defined one.
   `DQ_ASSERT_ALWAYS(a_status_code, clock, reset, !rsp_tvalid || rsp_code_ok,
                     "undefined status code")

endmodule

bind double_ended_queue dq_checker #(.DEPTH(DEPTH)) u_dq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// File: tb/testbench.sv
// Self-checking testbench for the bounded double-ended queue.
`timescale 1ns / 100ps

module testbench;

   localparam int KIND_W      = dq_pkg::KIND_W;
   localparam int VALUE_W     = dq_pkg::VALUE_W;
   localparam int INDEX_W     = dq_pkg::INDEX_W;
   localparam int LEN_W       = dq_pkg::LEN_W;
   localparam int DEPTH       = 16;
   localparam int ITEM_TOTAL  = 1050;
   localparam int DRAIN_WAIT  = 20;
   localparam int MAX_REPORTS = 10;
   localparam logic [KIND_W-1:0] KIND_TOP   = KIND_W'((1 << KIND_W) - 1);
   localparam logic [KIND_W-1:0] KIND_SPARE = KIND_W'(dq_pkg::RQ_READ + 1);

   typedef struct {
      logic [KIND_W-1:0]  kind;
      logic [VALUE_W-1:0] value;
      logic [INDEX_W-1:0] index;
   } dq_request_type;

   typedef struct {
      dq_pkg::status_type status;
      logic [VALUE_W-1:0] data;
      logic [LEN_W-1:0]   length;
   } dq_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [dq_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic [KIND_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [dq_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic [dq_pkg::STATUS_W-1:0] rsp_tuser;

   dq_request_type pending_requests[$];
   dq_result_type  expected_results[$];

   // Shadow of the queue contents used for prediction.
   logic [VALUE_W-1:0] deque_store [DEPTH];
   logic [INDEX_W-1:0] deque_head = '0;
   logic [LEN_W-1:0]   deque_count = '0;

   // Occupancy seen by the stimulus generator while it plans items.
   int plan_count = 0;

   int mismatches = 0;
   int req_gap = 0;
   int rsp_stall = 0;
   bit req_calm = 1'b0;
   bit rsp_calm = 1'b0;
   dq_result_type seen;

   double_ended_queue dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int pick_gap(input bit calm);
      int r;
      r = int'($urandom_range(0, 99));
      if (calm || r < 60) return 0;
      if (r < 90) return int'($urandom_range(1, 3));
      if (r < 98) return int'($urandom_range(4, 12));
      return int'($urandom_range(20, 60));
   endfunction

   task automatic predict_result(input dq_request_type rq);
      dq_result_type res;
      res.status = dq_pkg::ST_OK;
      res.data   = '0;
      case (rq.kind)
         dq_pkg::RQ_PUSH_BACK: begin
            if (deque_count >= DEPTH) begin
               res.status = dq_pkg::ST_FULL;
            end else begin
               deque_store[deque_head + deque_count[INDEX_W-1:0]] = rq.value;
               deque_count++;
            end
         end
         dq_pkg::RQ_PUSH_FRONT: begin
            if (deque_count >= DEPTH) begin
               res.status = dq_pkg::ST_FULL;
            end else begin
               deque_head--;
               deque_store[deque_head] = rq.value;
               deque_count++;
            end
         end
         dq_pkg::RQ_POP_BACK: begin
            if (deque_count == 0) begin
               res.status = dq_pkg::ST_EMPTY;
            end else begin
               deque_count--;
               res.data = deque_store[deque_head + deque_count[INDEX_W-1:0]];
            end
         end
         dq_pkg::RQ_POP_FRONT: begin
            if (deque_count == 0) begin
               res.status = dq_pkg::ST_EMPTY;
            end else begin
               res.data = deque_store[deque_head];
               deque_head++;
               deque_count--;
            end
         end
         dq_pkg::RQ_READ: begin
            if (rq.index >= deque_count) begin
               res.status = dq_pkg::ST_EMPTY;
            end else begin
               res.data = deque_store[deque_head + rq.index];
            end
         end
         default: begin
            // Undefined kinds leave everything alone and answer with ok.
         end
      endcase
      res.length = deque_count;
      expected_results.push_back(res);
   endtask

   task automatic plan_item(input logic [KIND_W-1:0] kind, input logic [VALUE_W-1:0] value,
                            input logic [INDEX_W-1:0] index);
      dq_request_type rq;
      rq.kind  = kind;
      rq.value = value;
      rq.index = index;
      pending_requests.push_back(rq);
      if ((kind == dq_pkg::RQ_PUSH_BACK || kind == dq_pkg::RQ_PUSH_FRONT) &&
          plan_count < DEPTH)
         plan_count++;
      else if ((kind == dq_pkg::RQ_POP_BACK || kind == dq_pkg::RQ_POP_FRONT) &&
               plan_count > 0)
         plan_count--;
   endtask

   function automatic logic [VALUE_W-1:0] random_value();
      int r;
      r = int'($urandom_range(0, 19));
      if (r == 0) return '0;
      if (r == 1) return '1;
      return VALUE_W'($urandom);
   endfunction

   function automatic logic [INDEX_W-1:0] random_index();
      if (plan_count > 0 && $urandom_range(0, 4) != 0)
         return INDEX_W'($urandom_range(0, plan_count - 1));
      return INDEX_W'($urandom_range(0, DEPTH - 1));
   endfunction

   // Stimulus plan: a directed opening, then bursts that fill, drain, mix or read.
   initial begin
      int mode;
      int burst;
      int r;
      logic [KIND_W-1:0] kind;
      plan_item(dq_pkg::RQ_POP_BACK, 32'h1234_5678, 4'd0);
      plan_item(dq_pkg::RQ_POP_FRONT, 32'hFFFF_FFFF, 4'd15);
      plan_item(dq_pkg::RQ_READ, 32'h0, 4'd15);
      plan_item(dq_pkg::RQ_READ, 32'h0, 4'd0);
      plan_item(KIND_TOP, 32'hDEAD_BEEF, 4'd3);
      plan_item(dq_pkg::RQ_PUSH_BACK, 32'h0000_0000, 4'd15);
      // Pushing at the front from head zero wraps the ring.
      plan_item(dq_pkg::RQ_PUSH_FRONT, 32'hFFFF_FFFF, 4'd0);
      plan_item(dq_pkg::RQ_PUSH_BACK, 32'hA5A5_A5A5, 4'd9);
      plan_item(dq_pkg::RQ_READ, 32'h0, 4'd0);
      plan_item(dq_pkg::RQ_READ, 32'h0, 4'd2);
      plan_item(dq_pkg::RQ_READ, 32'h0, 4'd3);
      plan_item(dq_pkg::RQ_READ, 32'hFFFF_FFFF, 4'd15);
      plan_item(dq_pkg::RQ_PUSH_FRONT, 32'h5A5A_5A5A, 4'd6);
      plan_item(dq_pkg::RQ_POP_BACK, 32'h0, 4'd0);
      plan_item(dq_pkg::RQ_POP_FRONT, 32'h0, 4'd0);
      plan_item(dq_pkg::RQ_POP_FRONT, 32'h0, 4'd0);
      plan_item(dq_pkg::RQ_POP_BACK, 32'h0, 4'd0);
      plan_item(dq_pkg::RQ_POP_FRONT, 32'h0, 4'd0);
      plan_item(dq_pkg::RQ_READ, 32'h0, 4'd0);
      plan_item(KIND_SPARE, 32'h0, 4'd0);
      plan_item(KIND_TOP - 1'b1, 32'h0, 4'd0);

      while (pending_requests.size() < ITEM_TOTAL) begin
         mode  = int'($urandom_range(0, 3));
         burst = int'($urandom_range(8, 40));
         repeat (burst) begin
            r = int'($urandom_range(0, 99));
            case (mode)
               0: kind = (r < 75) ? dq_pkg::RQ_PUSH_BACK : (r < 85) ? dq_pkg::RQ_READ :
                         (r < 97) ? dq_pkg::RQ_POP_BACK : KIND_TOP;
               1: kind = (r < 75) ? dq_pkg::RQ_POP_BACK : (r < 90) ? dq_pkg::RQ_READ :
                         (r < 98) ? dq_pkg::RQ_PUSH_BACK : KIND_TOP;
               2: kind = (r < 40) ? dq_pkg::RQ_PUSH_BACK : (r < 75) ? dq_pkg::RQ_POP_BACK :
                         (r < 96) ? dq_pkg::RQ_READ : KIND_TOP;
               default: kind = (r < 70) ? dq_pkg::RQ_READ : (r < 85) ? dq_pkg::RQ_PUSH_BACK :
                               (r < 98) ? dq_pkg::RQ_POP_BACK : KIND_TOP;
            endcase
            // Pick front or back, or one of the undefined kinds.
            if (kind == dq_pkg::RQ_PUSH_BACK || kind == dq_pkg::RQ_POP_BACK)
               kind = kind + KIND_W'($urandom_range(0, 1));
            else if (kind == KIND_TOP)
               kind = KIND_W'($urandom_range(KIND_SPARE, KIND_TOP));
            plan_item(kind, random_value(), random_index());
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   // Request driver.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_result(pending_requests.pop_front());
            if ($urandom_range(0, 79) == 0) req_calm = !req_calm;
            req_gap = pick_gap(req_calm);
         end
         if (req_tvalid && !req_tready) begin
            // Hold the item until it is taken.
         end else if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tuser  <= pending_requests[0].kind;
            req_tdata  <= {{(dq_pkg::REQ_TDATA_W - VALUE_W - INDEX_W){1'b0}},
                           pending_requests[0].index, pending_requests[0].value};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result monitor and receiver.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen.status = dq_pkg::status_type'(rsp_tuser);
            seen.data   = rsp_tdata[VALUE_W-1:0];
            seen.length = rsp_tdata[VALUE_W +: LEN_W];
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%0t: unexpected item status=%0d data=%h length=%0d",
                           $realtime, seen.status, seen.data, seen.length);
            end else begin
               dq_result_type want;
               want = expected_results.pop_front();
               if (want.status != seen.status || want.data != seen.data ||
                   want.length != seen.length) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display("%0t: mismatch expected status=%0d data=%h length=%0d, %s",
                              $realtime, want.status, want.data, want.length,
                              $sformatf("got status=%0d data=%h length=%0d",
                                        seen.status, seen.data, seen.length));
               end
            end
            if ($urandom_range(0, 79) == 0) rsp_calm = !rsp_calm;
            rsp_stall = pick_gap(rsp_calm);
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      wait (!reset);
      while (pending_requests.size() != 0 || req_tvalid || expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatches == 0 && expected_results.size() == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

   initial begin
      #3000000;
      $display("testbench: FAIL");
      $finish;
   end

endmodule
